// ===== hw/rtl/vrri_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vrri_pkg
// Shared types and constants for the video register file with raster IRQ.
// ----------------------------------------------------------------------------
package vrri_pkg;

  // Command codes carried by one input transfer
  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_TICK  = 2'd2
  } cmd_t;

  localparam int unsigned NUM_REGS        = 47;
  localparam int unsigned LINES_PER_FRAME = 312;

  localparam logic [8:0] COMPARE_ALIAS = 9'd511;

  // Register addresses with special behavior
  localparam logic [5:0] ADDR_CTRL1    = 6'h11;
  localparam logic [5:0] ADDR_RASTER   = 6'h12;
  localparam logic [5:0] ADDR_CTRL2    = 6'h16;
  localparam logic [5:0] ADDR_MEMPTR   = 6'h18;
  localparam logic [5:0] ADDR_IRQ_STAT = 6'h19;
  localparam logic [5:0] ADDR_IRQ_EN   = 6'h1A;
  localparam logic [5:0] ADDR_COLOR0   = 6'h20;
  localparam logic [5:0] LAST_REG      = 6'h2E;

  // Unused-bit fill patterns on readback
  localparam logic [7:0] FILL_CTRL2  = 8'hC0;
  localparam logic [7:0] FILL_MEMPTR = 8'h01;
  localparam logic [7:0] FILL_NIBBLE = 8'hF0;

endpackage : vrri_pkg
`default_nettype wire

// ===== hw/rtl/video_regs_raster_irq_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// video_regs_raster_irq_unit
// Video register file (47 bytes) with raster line counter and compare IRQ.
// ----------------------------------------------------------------------------
//
//  Channel  | Ports                                | Dir | Transfer when
//  ---------+--------------------------------------+-----+------------------
//  input    | in_valid/in_ready, in_cmd,           | in  | in_valid & in_ready
//           | in_reg_addr, in_wr_data              |     |
//  result   | out_valid/out_ready, out_rd_data,    | out | out_valid & out_ready
//           | out_irq                              |     |
//
//  One transfer in per clock while in_ready is high, one result per command.
//  Stage 1: state update at the input edge plus the registered register-file
//  read; stage 2: readback formatting into the output register.
//  Reset (rst_n low, synchronous) clears the counter, compare, status, the
//  register valid bits and both pipeline stages; no clearing pass is needed.
//  A stalled output holds its result; the middle stage still takes one more
//  transfer, so in_ready only drops when both stages are full.
//
`default_nettype none
module video_regs_raster_irq_unit #(
  parameter int unsigned LINES_PER_FRAME = vrri_pkg::LINES_PER_FRAME
) (
  input  wire logic       clk,
  input  wire logic       rst_n,

  input  wire logic       in_valid,
  output      logic       in_ready,
  input  wire logic [1:0] in_cmd,
  input  wire logic [5:0] in_reg_addr,
  input  wire logic [7:0] in_wr_data,

  output      logic       out_valid,
  input  wire logic       out_ready,
  output      logic [7:0] out_rd_data,
  output      logic       out_irq
);

  // --------------------------------------------------------------------------
  // Handshake and pipeline control
  // --------------------------------------------------------------------------
  logic in_fire;
  logic out_load;

  logic s1_vld_r, s1_vld_nxt;
  logic out_valid_r, out_valid_nxt;

  assign out_load = s1_vld_r & (~out_valid_r | out_ready);
  assign in_ready = ~s1_vld_r | out_load;
  assign in_fire  = in_valid & in_ready;

  assign s1_vld_nxt    = in_fire | (s1_vld_r & ~out_load);
  assign out_valid_nxt = out_load | (out_valid_r & ~out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_vld_r    <= s1_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Command decode
  // --------------------------------------------------------------------------
  logic is_read, is_write, is_tick;
  logic addr_ok;

  always_comb begin
    is_read  = 1'b0;
    is_write = 1'b0;
    is_tick  = 1'b0;
    unique case (in_cmd)
      vrri_pkg::CMD_READ:  is_read  = 1'b1;
      vrri_pkg::CMD_WRITE: is_write = 1'b1;
      vrri_pkg::CMD_TICK:  is_tick  = 1'b1;
      default: ;   // unused code: no state change
    endcase
  end

  // Addresses above the last register are dead: writes dropped, reads zero
  assign addr_ok = (in_reg_addr <= vrri_pkg::LAST_REG);

  // --------------------------------------------------------------------------
  // Architectural state
  // --------------------------------------------------------------------------
  logic [8:0] line_r,  line_nxt;
  logic [8:0] cmp_r,   cmp_nxt;
  logic [3:0] en_r,    en_nxt;     // IRQ enable, only the low nibble exists
  logic [3:0] stat_r,  stat_nxt;   // IRQ status low nibble; bit 7 = |nibble

  logic [9:0] line_inc;
  logic [8:0] line_tick;
  logic       raster_hit;
  logic       wr_ok;

  assign wr_ok    = in_fire & is_write & addr_ok;
  assign line_inc = {1'b0, line_r} + 10'd1;
  // Wrap at the frame length; also catches a line parked past the end
  assign line_tick = (line_inc >= 10'(LINES_PER_FRAME)) ? 9'd0 : line_inc[8:0];
  // A compare value of 511 also fires on line 0
  assign raster_hit = (line_tick == cmp_r) ||
                      ((cmp_r == vrri_pkg::COMPARE_ALIAS) && (line_tick == 9'd0));

  always_comb begin
    line_nxt = line_r;
    cmp_nxt  = cmp_r;
    en_nxt   = en_r;
    stat_nxt = stat_r;
    if (in_fire && is_tick) begin
      line_nxt = line_tick;
      stat_nxt = {stat_r[3:1], raster_hit} & en_r;
    end
    if (wr_ok) begin
      unique case (in_reg_addr)
        vrri_pkg::ADDR_CTRL1:    cmp_nxt  = {in_wr_data[7], cmp_r[7:0]};
        vrri_pkg::ADDR_RASTER:   cmp_nxt  = {cmp_r[8], in_wr_data};
        // Write-one-to-keep: only bits written as 1 survive
        vrri_pkg::ADDR_IRQ_STAT: stat_nxt = stat_r & in_wr_data[3:0] & en_r;
        // Enable change takes effect on status at the next tick or status write
        vrri_pkg::ADDR_IRQ_EN:   en_nxt   = in_wr_data[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_r <= '0;
      cmp_r  <= '0;
      en_r   <= '0;
      stat_r <= '0;
    end else begin
      line_r <= line_nxt;
      cmp_r  <= cmp_nxt;
      en_r   <= en_nxt;
      stat_r <= stat_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Register file: one write port, one registered read port.
  // Per-entry valid bits give the all-zero reset value.
  // --------------------------------------------------------------------------
  logic [7:0]                   mem [vrri_pkg::NUM_REGS];
  logic [vrri_pkg::NUM_REGS-1:0] mem_vld_r;
  logic [7:0]                   mem_wdata;

  assign mem_wdata = (in_reg_addr == vrri_pkg::ADDR_IRQ_EN) ?
                     {4'h0, in_wr_data[3:0]} : in_wr_data;

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem[in_reg_addr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mem_vld_r <= '0;
    end else if (wr_ok) begin
      mem_vld_r[in_reg_addr] <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: registered read plus snapshot of what the readback needs
  // --------------------------------------------------------------------------
  logic [7:0] s1_mem_r;
  logic       s1_mem_vld_r;
  logic       s1_rd_r;
  logic [5:0] s1_addr_r;
  logic [8:0] s1_line_r;
  logic [3:0] s1_stat_r;
  logic       s1_irq_r;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_rd_r   <= is_read & addr_ok;
      s1_addr_r <= in_reg_addr;
      s1_line_r <= line_r;
      s1_stat_r <= stat_r;
      s1_irq_r  <= |stat_nxt;   // level after this command
      if (addr_ok) begin
        s1_mem_r     <= mem[in_reg_addr];
        s1_mem_vld_r <= mem_vld_r[in_reg_addr];
      end else begin
        s1_mem_vld_r <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: readback formatting into the output register
  // --------------------------------------------------------------------------
  logic [7:0] rd_raw;
  logic [7:0] rd_fmt;
  logic [7:0] out_rd_data_r;
  logic       out_irq_r;

  assign rd_raw = s1_mem_vld_r ? s1_mem_r : 8'h00;

  always_comb begin
    rd_fmt = 8'h00;
    if (s1_rd_r) begin
      unique case (s1_addr_r) inside
        vrri_pkg::ADDR_CTRL1:    rd_fmt = {s1_line_r[8], rd_raw[6:0]};
        vrri_pkg::ADDR_RASTER:   rd_fmt = s1_line_r[7:0];
        vrri_pkg::ADDR_CTRL2:    rd_fmt = rd_raw | vrri_pkg::FILL_CTRL2;
        vrri_pkg::ADDR_MEMPTR:   rd_fmt = rd_raw | vrri_pkg::FILL_MEMPTR;
        vrri_pkg::ADDR_IRQ_STAT: rd_fmt = {|s1_stat_r, 3'b111, s1_stat_r};
        vrri_pkg::ADDR_IRQ_EN,
        [vrri_pkg::ADDR_COLOR0:vrri_pkg::LAST_REG]:
                                 rd_fmt = rd_raw | vrri_pkg::FILL_NIBBLE;
        default:                 rd_fmt = rd_raw;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_rd_data_r <= rd_fmt;
      out_irq_r     <= s1_irq_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_rd_data = out_rd_data_r;
  assign out_irq     = out_irq_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
`ifndef SYNTH
  a_stall_only_when_full : assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_vld_r && out_valid_r && !out_ready))
    else $error("input stalled with a free pipeline slot");

  a_line_in_frame : assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && is_tick) |=> ({1'b0, line_r} < 10'(LINES_PER_FRAME)))
    else $error("raster line past frame end after a tick");

  a_status_masked : assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && is_tick) |=> ((stat_r & ~en_r) == 4'h0))
    else $error("IRQ status holds a disabled source after a tick");

  a_cmp_low_write : assert property (@(posedge clk) disable iff (!rst_n)
    (wr_ok && (in_reg_addr == vrri_pkg::ADDR_RASTER)) |=>
      (cmp_r[7:0] == $past(in_wr_data)))
    else $error("compare low byte not taken from the write");
`endif

endmodule : video_regs_raster_irq_unit
`default_nettype wire

// ===== verif/video_regs_raster_irq_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// video_regs_raster_irq_unit_tb
// Self-checking bench for the video register file with raster compare IRQ.
// A queue-fed driver sends register reads, writes and raster line ticks.
// Each accepted transfer goes through a shadow copy of the registers, line
// counter, compare value and IRQ status. That copy predicts the readback and
// the IRQ level. The monitor checks every result transfer in order.
// ----------------------------------------------------------------------------
module video_regs_raster_irq_unit_tb;
  import vrri_pkg::*;

  // Command code with no function in the block; it must leave all state alone
  localparam logic [1:0] CMD_UNUSED  = 2'd3;
  localparam logic [7:0] FILL_STAT   = 8'h70;  // unused status bits read as 1
  localparam logic [7:0] NIBBLE_MASK = 8'h0F;

  localparam int unsigned OP_TARGET    = 1950;
  localparam int unsigned IDLE_PCT     = 16;
  // Window of cycles where neither side idles at random
  localparam int unsigned CALM_FROM    = 1500;
  localparam int unsigned CALM_TO      = 3000;
  // Long receiver hold-off, repeated a few times, to fill both pipe stages
  localparam int unsigned HOLD_CYCLES  = 80;
  localparam int unsigned FIRST_HOLD   = 300;
  localparam int unsigned HOLD_EVERY   = 700;
  localparam int unsigned DRAIN_CYCLES = 8;

  typedef struct packed {
    logic [1:0] cmd;
    logic [5:0] addr;
    logic [7:0] data;
  } bus_op_t;

  typedef struct packed {
    logic [7:0] rd_data;
    logic       irq;
  } resp_t;

  logic       clk         = 1'b0;
  logic       rst_n       = 1'b0;
  logic       in_valid    = 1'b0;
  logic       in_ready;
  logic [1:0] in_cmd      = 2'd0;
  logic [5:0] in_reg_addr = 6'd0;
  logic [7:0] in_wr_data  = 8'd0;
  logic       out_valid;
  logic       out_ready   = 1'b0;
  logic [7:0] out_rd_data;
  logic       out_irq;

  video_regs_raster_irq_unit i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_cmd      (in_cmd),
    .in_reg_addr (in_reg_addr),
    .in_wr_data  (in_wr_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_rd_data (out_rd_data),
    .out_irq     (out_irq)
  );

  // 20 ns period, two delays
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Free-running cycle count; sampled pre-edge by both sides for the calm window
  int unsigned tb_cycle = 0;
  logic        calm;
  always @(posedge clk) begin
    tb_cycle <= tb_cycle + 1;
  end
  assign calm = (tb_cycle >= CALM_FROM) && (tb_cycle < CALM_TO);

  // --------------------------------------------------------------------------
  // Shadow state of the block: register bytes, raster line, 9-bit compare,
  // IRQ status and the IRQ line level.
  // --------------------------------------------------------------------------
  logic [7:0] shadow_regs [NUM_REGS];
  logic [8:0] shadow_line;
  logic [8:0] shadow_cmp;
  logic [7:0] shadow_stat;
  logic       shadow_irq;

  bus_op_t    op_feed [$];    // ops waiting to be driven
  resp_t      resp_due [$];   // predicted results, oldest first
  int         mismatches = 0;

  // Any pending status bit sets the summary bit 7 and raises the line
  function automatic void refresh_irq();
    if (shadow_stat != 8'h00) begin
      shadow_stat[7] = 1'b1;
      shadow_irq     = 1'b1;
    end else begin
      shadow_irq = 1'b0;
    end
  endfunction

  // Applies one bus op to the shadow state; returns the readback and IRQ level
  function automatic resp_t predict_bus_op(bus_op_t op);
    resp_t       r;
    int unsigned nxt;
    r.rd_data = 8'h00;
    case (op.cmd)
      CMD_READ: begin
        // Addresses past the last register read as zero
        if (op.addr > LAST_REG)
          r.rd_data = 8'h00;
        else if (op.addr == ADDR_CTRL1)
          r.rd_data = {shadow_line[8], shadow_regs[op.addr][6:0]};
        else if (op.addr == ADDR_RASTER)
          r.rd_data = shadow_line[7:0];
        else if (op.addr == ADDR_CTRL2)
          r.rd_data = shadow_regs[op.addr] | FILL_CTRL2;
        else if (op.addr == ADDR_MEMPTR)
          r.rd_data = shadow_regs[op.addr] | FILL_MEMPTR;
        else if (op.addr == ADDR_IRQ_STAT)
          r.rd_data = shadow_stat | FILL_STAT;
        else if (op.addr == ADDR_IRQ_EN || op.addr >= ADDR_COLOR0)
          r.rd_data = shadow_regs[op.addr] | FILL_NIBBLE;
        else
          r.rd_data = shadow_regs[op.addr];
      end
      CMD_WRITE: begin
        // Writes past the last register are dropped
        if (op.addr <= LAST_REG) begin
          shadow_regs[op.addr] = op.data;
          case (op.addr)
            ADDR_CTRL1:  shadow_cmp[8]   = op.data[7];
            ADDR_RASTER: shadow_cmp[7:0] = op.data;
            ADDR_IRQ_STAT: begin
              // only bits written as 1 (and enabled) survive
              shadow_stat = shadow_stat & op.data & NIBBLE_MASK & shadow_regs[ADDR_IRQ_EN];
              refresh_irq();
            end
            ADDR_IRQ_EN: shadow_regs[ADDR_IRQ_EN] = op.data & NIBBLE_MASK;
            default: ;
          endcase
        end
      end
      CMD_TICK: begin
        nxt = 32'(shadow_line) + 1;
        if (nxt >= LINES_PER_FRAME)
          nxt = 0;
        shadow_line = nxt[8:0];
        // a compare of 511 also hits line 0
        shadow_stat[0] = (shadow_line == shadow_cmp) ||
                         (shadow_cmp == COMPARE_ALIAS && shadow_line == 9'd0);
        shadow_stat = shadow_stat & shadow_regs[ADDR_IRQ_EN];
        refresh_irq();
      end
      default: ;  // unused command: no state change
    endcase
    r.irq = shadow_irq;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Driver: offers the next queued op, holds it until the transfer, and runs
  // the prediction on every accepted transfer.
  // --------------------------------------------------------------------------
  bus_op_t next_op;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      for (int i = 0; i < NUM_REGS; i++)
        shadow_regs[i] = 8'h00;
      shadow_line = 9'd0;
      shadow_cmp  = 9'd0;
      shadow_stat = 8'h00;
      shadow_irq  = 1'b0;
    end else begin
      if (in_valid && in_ready)
        resp_due.push_back(predict_bus_op({in_cmd, in_reg_addr, in_wr_data}));
      // Free slot: either nothing was offered or the offer just transferred
      if (!in_valid || in_ready) begin
        if (op_feed.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
          next_op = op_feed.pop_front();
          in_cmd      <= next_op.cmd;
          in_reg_addr <= next_op.addr;
          in_wr_data  <= next_op.data;
          in_valid    <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: random backpressure plus periodic long hold-offs; checks each
  // result transfer against the oldest prediction.
  // --------------------------------------------------------------------------
  resp_t       want;
  int unsigned resp_count = 0;
  int unsigned hold_left  = 0;
  int unsigned next_hold  = FIRST_HOLD;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (resp_due.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual rd_data %02h irq %0b",
                   $time, out_rd_data, out_irq);
          mismatches++;
        end else begin
          want = resp_due.pop_front();
          if (out_rd_data !== want.rd_data) begin
            $display("%0t: rd_data expected %02h actual %02h",
                     $time, want.rd_data, out_rd_data);
            mismatches++;
          end
          if (out_irq !== want.irq) begin
            $display("%0t: irq expected %0b actual %0b", $time, want.irq, out_irq);
            mismatches++;
          end
        end
        resp_count++;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (resp_count >= next_hold) begin
        // long stall: the sender keeps offering, so the pipe fills up
        hold_left = HOLD_CYCLES;
        next_hold += HOLD_EVERY;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus generation. gen_line follows the raster line as ticks get
  // queued, so compare values can be aimed a few lines ahead.
  // --------------------------------------------------------------------------
  int unsigned gen_line = 0;

  task automatic queue_op(logic [1:0] c, logic [5:0] a, logic [7:0] d);
    op_feed.push_back({c, a, d});
    if (c == CMD_TICK)
      gen_line = (gen_line + 1) % LINES_PER_FRAME;
  endtask

  initial begin
    logic [8:0]  target;
    logic [7:0]  en_byte;
    logic [7:0]  ctrl_byte;
    logic [1:0]  noise_cmd;
    int unsigned run;

    // Directed: fill patterns, out-of-range access, enable masking, compare
    // hit with ack, compare 511, unused command
    queue_op(CMD_READ,   ADDR_IRQ_STAT, 8'h00);
    queue_op(CMD_READ,   6'h3F,         8'hFF);
    queue_op(CMD_WRITE,  6'h2F,         8'hFF);
    queue_op(CMD_READ,   6'h2F,         8'h00);
    queue_op(CMD_WRITE,  LAST_REG,      8'h5A);
    queue_op(CMD_READ,   LAST_REG,      8'h00);
    queue_op(CMD_WRITE,  6'h00,         8'hAA);
    queue_op(CMD_READ,   6'h00,         8'h00);
    queue_op(CMD_WRITE,  ADDR_CTRL2,    8'h00);
    queue_op(CMD_READ,   ADDR_CTRL2,    8'h00);
    queue_op(CMD_WRITE,  ADDR_MEMPTR,   8'h00);
    queue_op(CMD_READ,   ADDR_MEMPTR,   8'h00);
    queue_op(CMD_WRITE,  ADDR_IRQ_EN,   8'hFF);
    queue_op(CMD_READ,   ADDR_IRQ_EN,   8'h00);
    queue_op(CMD_WRITE,  ADDR_CTRL1,    8'h00);
    queue_op(CMD_WRITE,  ADDR_RASTER,   8'h01);
    queue_op(CMD_TICK,   6'h00,         8'h00);  // line 1 hits compare 1
    queue_op(CMD_READ,   ADDR_IRQ_STAT, 8'h00);
    queue_op(CMD_WRITE,  ADDR_IRQ_STAT, 8'h00);  // ack by writing zeros
    queue_op(CMD_READ,   ADDR_IRQ_STAT, 8'h00);
    queue_op(CMD_WRITE,  ADDR_CTRL1,    8'hFF);
    queue_op(CMD_READ,   ADDR_CTRL1,    8'h00);
    queue_op(CMD_WRITE,  ADDR_RASTER,   8'hFF);  // compare now 511
    queue_op(CMD_UNUSED, 6'h3F,         8'hFF);
    queue_op(CMD_READ,   ADDR_RASTER,   8'h00);
    queue_op(CMD_TICK,   6'h3F,         8'hFF);

    // Random: mostly enable/compare/tick/ack sequences, some loose noise
    while (op_feed.size() < OP_TARGET) begin
      if ($urandom_range(0, 99) < 70) begin
        en_byte = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 9) < 8)
          en_byte[0] = 1'b1;
        queue_op(CMD_WRITE, ADDR_IRQ_EN, en_byte);
        if (gen_line > 285 && $urandom_range(0, 1) == 1) begin
          // aliased compare, run the ticks across the frame wrap
          target = COMPARE_ALIAS;
          run    = LINES_PER_FRAME - gen_line + $urandom_range(0, 5);
        end else begin
          target = 9'((gen_line + $urandom_range(1, 25)) % LINES_PER_FRAME);
          run    = $urandom_range(1, 40);
        end
        ctrl_byte    = 8'($urandom_range(0, 255));
        ctrl_byte[7] = target[8];
        queue_op(CMD_WRITE, ADDR_CTRL1, ctrl_byte);
        queue_op(CMD_WRITE, ADDR_RASTER, target[7:0]);
        repeat (run) begin
          if ($urandom_range(0, 9) == 0)
            queue_op(CMD_READ, 6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)));
          queue_op(CMD_TICK, 6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)));
        end
        queue_op(CMD_READ, ADDR_IRQ_STAT, 8'($urandom_range(0, 255)));
        queue_op(CMD_WRITE, ADDR_IRQ_STAT, 8'($urandom_range(0, 255)));
        queue_op(CMD_READ, ADDR_IRQ_STAT, 8'($urandom_range(0, 255)));
      end else begin
        noise_cmd = ($urandom_range(0, 99) < 5) ? CMD_UNUSED : 2'($urandom_range(0, 2));
        queue_op(noise_cmd, 6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)));
      end
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // all ops transferred, then all results back, then a short drain
    while (op_feed.size() != 0 || in_valid)
      @(posedge clk);
    while (resp_due.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  // Watchdog
  initial begin
    #4_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
